### rtl/frft_pkg.sv
// ----------------------------------------------------------------------------
// frft_pkg
// Shared constants, the prime table and the sequencer state type for the
// finite radix fraction test.
// ----------------------------------------------------------------------------
package frft_pkg;

	localparam int VALUE_BITS = 32;
	localparam int RADIX_W    = 6;
	localparam int DIV_CNT_W  = $clog2(VALUE_BITS);

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// every prime that can divide a base of 36 or less
	localparam int NUM_PRIMES = 11;
	localparam int PIDX_W     = $clog2(NUM_PRIMES);

	localparam logic [RADIX_W-1:0] PRIMES [NUM_PRIMES] = '{
		RADIX_W'(2),  RADIX_W'(3),  RADIX_W'(5),  RADIX_W'(7),
		RADIX_W'(11), RADIX_W'(13), RADIX_W'(17), RADIX_W'(19),
		RADIX_W'(23), RADIX_W'(29), RADIX_W'(31)
	};

	localparam logic [PIDX_W-1:0] PIDX_LAST = PIDX_W'(NUM_PRIMES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_RP,
		ST_RQ,
		ST_PCHK,
		ST_STRIP,
		ST_DONE
	} state_t;

endpackage

### rtl/frft_if.sv
// ----------------------------------------------------------------------------
// frft_in_if / frft_out_if
// Valid/ready channels carrying the fraction in and the test result out.
// ----------------------------------------------------------------------------
interface frft_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] numerator;
	logic [31:0] denominator;

	modport source (output valid, output numerator, output denominator, input ready);
	modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frft_out_if;
	logic        valid;
	logic        ready;
	logic        is_finite;
	logic [31:0] reduced_numerator;
	logic [31:0] reduced_denominator;
	logic        status;

	modport source (output valid, output is_finite, output reduced_numerator,
		output reduced_denominator, output status, input ready);
	modport sink   (input valid, input is_finite, input reduced_numerator,
		input reduced_denominator, input status, output ready);
endinterface

### rtl/frft_div.sv
// ----------------------------------------------------------------------------
// frft_div
// Restoring unsigned divider, one quotient bit per cycle. A start pulse
// loads the operands; done pulses once quotient and remainder are valid.
// ----------------------------------------------------------------------------
module frft_div
	import frft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [VALUE_BITS-1:0] remainder
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [VALUE_BITS-1:0] dvs_q;

	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   diff;
	logic                  qbit;

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign qbit    = ~diff[VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(VALUE_BITS - 1));
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
			quo_q <= {quo_q[VALUE_BITS-2:0], qbit};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/finite_radix_fraction_test.sv
// work: every division runs on the shared divider; an item takes E + 2 + P + S
// divisions: E euclid steps (at most 46), two reductions, P prime checks
// (11 when the base is valid) and S factor strips (at most 34 more); a zero
// denominator skips the divider and goes straight to the result
// throughput: one item at a time, ready again once the result is registered
// reset: arst_n clears the sequencer and output valid and sets radix to 10
// ----------------------------------------------------------------------------
// finite_radix_fraction_test
// Reduces a fraction by its gcd and tests whether the reduced denominator has
// only prime factors of the configured base.
// ----------------------------------------------------------------------------
module finite_radix_fraction_test
	import frft_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RADIX_W-1:0] cfg_wdata,
	frft_in_if.sink            req,
	frft_out_if.source         rsp
);

	state_t state_q, state_d;

	logic [RADIX_W-1:0]    radix_q;
	logic [VALUE_BITS-1:0] p_q;
	logic [VALUE_BITS-1:0] q_q;
	logic [VALUE_BITS-1:0] b_q;
	logic [VALUE_BITS-1:0] rp_q;
	logic [VALUE_BITS-1:0] rq_q;
	logic [VALUE_BITS-1:0] w_q;
	logic [PIDX_W-1:0]     pidx_q;
	logic                  bad_q;

	logic                  out_valid_q;
	logic                  out_fin_q;
	logic [VALUE_BITS-1:0] out_rp_q;
	logic [VALUE_BITS-1:0] out_rq_q;
	logic                  out_status_q;

	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dvd;
	logic [VALUE_BITS-1:0] div_dvs;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [VALUE_BITS-1:0] div_rem;

	logic                  in_beat;
	logic                  out_load;
	logic                  bad_radix;
	logic                  last_prime;
	logic [PIDX_W-1:0]     pidx_nxt;

	assign in_beat    = req.valid && req.ready;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign bad_radix  = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
	assign last_prime = (pidx_q == PIDX_LAST);
	assign pidx_nxt   = last_prime ? pidx_q : pidx_q + 1'b1;

	frft_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = VALUE_BITS'(radix_q);
		div_dvs   = VALUE_BITS'(PRIMES[pidx_nxt]);
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					if (req.denominator == '0) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						div_dvd   = req.numerator;
						div_dvs   = req.denominator;
						state_d   = ST_GCD;
					end
				end
			end
			ST_GCD: begin
				if (div_done) begin
					div_start = 1'b1;
					if (div_rem == '0) begin
						div_dvd = p_q;
						div_dvs = b_q;
						state_d = ST_RP;
					end else begin
						div_dvd = b_q;
						div_dvs = div_rem;
					end
				end
			end
			ST_RP: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = q_q;
					div_dvs   = b_q;
					state_d   = ST_RQ;
				end
			end
			ST_RQ: begin
				if (div_done) begin
					if (bad_q) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						div_dvd   = VALUE_BITS'(radix_q);
						div_dvs   = VALUE_BITS'(PRIMES[0]);
						state_d   = ST_PCHK;
					end
				end
			end
			ST_PCHK, ST_STRIP: begin
				if (div_done) begin
					if (div_rem == '0) begin
						// prime divides the base, or divided w again: keep stripping
						div_start = 1'b1;
						div_dvd   = (state_q == ST_STRIP) ? div_quo : w_q;
						div_dvs   = VALUE_BITS'(PRIMES[pidx_q]);
						state_d   = ST_STRIP;
					end else if (last_prime) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						div_dvd   = VALUE_BITS'(radix_q);
						div_dvs   = VALUE_BITS'(PRIMES[pidx_nxt]);
						state_d   = ST_PCHK;
					end
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					p_q    <= req.numerator;
					q_q    <= req.denominator;
					b_q    <= req.denominator;
					bad_q  <= bad_radix;
					pidx_q <= '0;
					// zero denominator passes the numerator through
					rp_q   <= req.numerator;
					rq_q   <= '0;
					w_q    <= '0;
				end
			end
			ST_GCD: begin
				if (div_done && div_rem != '0) begin
					b_q <= div_rem;
				end
			end
			ST_RP: begin
				if (div_done) begin
					rp_q <= div_quo;
				end
			end
			ST_RQ: begin
				if (div_done) begin
					rq_q <= div_quo;
					w_q  <= div_quo;
				end
			end
			ST_PCHK, ST_STRIP: begin
				if (div_done) begin
					if (state_q == ST_STRIP && div_rem == '0) begin
						w_q <= div_quo;
					end
					if (div_rem != '0) begin
						pidx_q <= pidx_nxt;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_fin_q    <= !bad_q && (w_q == VALUE_BITS'(1));
			out_rp_q     <= rp_q;
			out_rq_q     <= rq_q;
			out_status_q <= bad_q;
		end
	end

	assign req.ready               = (state_q == ST_IDLE);
	assign rsp.valid               = out_valid_q;
	assign rsp.is_finite           = out_fin_q;
	assign rsp.reduced_numerator   = out_rp_q;
	assign rsp.reduced_denominator = out_rq_q;
	assign rsp.status              = out_status_q;

endmodule

### rtl/frft_chk.sv
// ----------------------------------------------------------------------------
// frft_chk
// Port-level checks for the finite radix fraction test, bound to the top.
// ----------------------------------------------------------------------------
module frft_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_is_finite,
	input logic [31:0] rsp_reduced_numerator,
	input logic [31:0] rsp_reduced_denominator,
	input logic        rsp_status
);

	// a stalled result beat stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// one fraction in flight: ready falls after every accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken while an item is in flight");

	// a finite result needs a valid base and a nonzero denominator
	a_fin_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_finite |-> !rsp_status && rsp_reduced_denominator != 32'd0)
		else $error("finite reported with bad base or zero denominator");

	// zero over a nonzero denominator reduces to zero over one; zero over zero stays
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_reduced_numerator == 32'd0 |->
			rsp_reduced_denominator == 32'd1 || rsp_reduced_denominator == 32'd0)
		else $error("zero numerator not reduced to zero over one");

endmodule

bind finite_radix_fraction_test frft_chk u_frft_chk (
	.clk                     (clk),
	.arst_n                  (arst_n),
	.req_valid               (req.valid),
	.req_ready               (req.ready),
	.rsp_valid               (rsp.valid),
	.rsp_ready               (rsp.ready),
	.rsp_is_finite           (rsp.is_finite),
	.rsp_reduced_numerator   (rsp.reduced_numerator),
	.rsp_reduced_denominator (rsp.reduced_denominator),
	.rsp_status              (rsp.status)
);

### tb/tb_finite_radix_fraction_test.sv
// ----------------------------------------------------------------------------
// tb_finite_radix_fraction_test
// Sends fractions over the request channel and checks every reduced fraction
// and finite/status flag against a predictor that does its own gcd and
// factor stripping. Walks the base through valid, edge and out-of-range
// settings. Both channels see random idle bursts, one long receiver hold-off
// and a full drain before each base change, once mid-phase and at the end.
// ----------------------------------------------------------------------------
module tb_finite_radix_fraction_test;
	import frft_pkg::*;

	localparam int          CYCLE_LIMIT     = 20_000_000;
	localparam int          NUM_PHASES      = 12;
	localparam int          PHASE_ITEMS     = 86;
	localparam int          HOLD_CYCLES     = 8000;
	localparam int          SETTLE_CYCLES   = 200;
	localparam logic        STATUS_OK       = 1'b0;
	localparam logic        STATUS_BAD_BASE = 1'b1;
	localparam logic [31:0] FULL_SCALE      = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        is_finite;
		logic [31:0] rnum;
		logic [31:0] rden;
		logic        status;
	} verdict_t;

	class frac_scoreboard;
		verdict_t           verdicts[$];
		logic [RADIX_W-1:0] radix;
		int                 errors;

		function new();
			radix  = RADIX_RESET;
			errors = 0;
		endfunction

		function int pending();
			return verdicts.size();
		endfunction

		function logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
			logic [63:0] t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		// divide out every factor shared with the base; terminates iff 1 is left
		function bit strips_to_one(logic [63:0] q, logic [63:0] r);
			logic [63:0] g;
			if (q == 0 || r < 2)
				return 1'b0;
			g = gcd64(q, r);
			while (g > 1) begin
				q = q / g;
				g = gcd64(q, g);
				if (g <= 1)
					g = gcd64(q, r);
			end
			return q == 1;
		endfunction

		function void note_fraction(logic [31:0] num, logic [31:0] den);
			logic [63:0] g;
			logic        bad;
			verdict_t    v;
			bad      = (radix < RADIX_MIN) || (radix > RADIX_MAX);
			v.status = bad ? STATUS_BAD_BASE : STATUS_OK;
			if (den == 0) begin
				v.rnum      = num;
				v.rden      = 32'd0;
				v.is_finite = 1'b0;
			end else begin
				g           = gcd64(64'(num), 64'(den));
				v.rnum      = 32'(64'(num) / g);
				v.rden      = 32'(64'(den) / g);
				v.is_finite = !bad && strips_to_one(64'(v.rden), 64'(radix));
			end
			verdicts.push_back(v);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_verdict(logic fin, logic [31:0] rn, logic [31:0] rd, logic st);
			verdict_t want;
			if (verdicts.size() == 0) begin
				report("result beat with nothing outstanding");
				return;
			end
			want = verdicts.pop_front();
			if (fin !== want.is_finite)
				report($sformatf("is_finite %0b, want %0b", fin, want.is_finite));
			if (rn !== want.rnum)
				report($sformatf("reduced_numerator %0d, want %0d", rn, want.rnum));
			if (rd !== want.rden)
				report($sformatf("reduced_denominator %0d, want %0d", rd, want.rden));
			if (st !== want.status)
				report($sformatf("status %0b, want %0b", st, want.status));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [RADIX_W-1:0] cfg_wdata;

	frft_in_if  req();
	frft_out_if rsp();

	finite_radix_fraction_test dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	frac_scoreboard sb;
	bit             calm;
	bit             hold_req;
	int             cycle_count;

	int small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("finite_radix_fraction_test test failed");
			$finish;
		end
	end

	// both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_fraction(req.numerator, req.denominator);
			if (rsp.valid && rsp.ready)
				sb.check_verdict(rsp.is_finite, rsp.reduced_numerator,
					rsp.reduced_denominator, rsp.status);
		end
	end

	// result side back-pressure
	initial begin
		int hold_left;
		int stall_left;
		hold_left  = 0;
		stall_left = 0;
		rsp.ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (!arst_n) begin
				rsp.ready <= 1'b0;
			end else if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_fraction(logic [31:0] num, logic [31:0] den);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.numerator   <= num;
		req.denominator <= den;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_radix(logic [RADIX_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.radix = value;
	endtask

	task automatic make_fraction(logic [RADIX_W-1:0] r, output logic [31:0] num,
		output logic [31:0] den);
		int          kind;
		int          p;
		int          n_f;
		int          fac[$];
		logic [63:0] d;
		logic [63:0] g;
		logic [63:0] a;
		logic [63:0] b;
		foreach (small_primes[i])
			if (r != 0 && r % small_primes[i] == 0)
				fac.push_back(small_primes[i]);
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			// denominator built from primes, mostly those of the base
			d   = 1;
			n_f = $urandom_range(1, 20);
			repeat (n_f) begin
				if (fac.size() > 0 && $urandom_range(0, 4) != 0)
					p = fac[$urandom_range(0, fac.size() - 1)];
				else
					p = small_primes[$urandom_range(0, 10)];
				if (d * p <= 64'(FULL_SCALE))
					d = d * p;
			end
			den = 32'(d);
			num = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1000);
		end else if (kind < 55) begin
			g   = $urandom_range(1, 65535);
			a   = $urandom_range(0, 32'(64'(FULL_SCALE) / g));
			b   = $urandom_range(1, 32'(64'(FULL_SCALE) / g));
			num = 32'(a * g);
			den = 32'(b * g);
		end else if (kind < 85) begin
			num = $urandom();
			den = $urandom();
		end else if (kind < 95) begin
			num = $urandom_range(0, 50);
			den = $urandom_range(1, 50);
		end else if (kind < 99) begin
			num = ($urandom_range(0, 2) == 0) ? 32'd0 : ($urandom_range(0, 1) ? 32'd1 : FULL_SCALE);
			den = $urandom_range(0, 1) ? 32'd1 : FULL_SCALE;
		end else begin
			num = $urandom();
			den = 32'd0;
		end
	endtask

	initial begin
		logic [31:0]        dir_num[21];
		logic [31:0]        dir_den[21];
		logic [RADIX_W-1:0] phase_radix[NUM_PHASES];
		logic [31:0]        num;
		logic [31:0]        den;

		// fibonacci pair forces the longest euclid run
		dir_num = '{32'd0, 32'd0, 32'd1, FULL_SCALE, FULL_SCALE, 32'd1, 32'd1, 32'd3,
			32'd6, 32'd2, 32'd1, 32'd7, 32'd1, 32'd1, 32'd1836311903, 32'hAAAA_AAAA,
			32'd5, 32'd0, FULL_SCALE, 32'h8000_0000, 32'd12};
		dir_den = '{32'd1, FULL_SCALE, 32'd1, FULL_SCALE, 32'd1, FULL_SCALE, 32'd3, 32'd20,
			32'd4, 32'd6, 32'd7, 32'h8000_0000, 32'd1000000000, 32'd3486784401,
			32'd2971215073, 32'h5555_5555, 32'd0, 32'd0, 32'd0, 32'hC000_0000, 32'd1024};
		phase_radix = '{RADIX_MIN, RADIX_MAX, 6'd0, 6'd63, 6'd1, RADIX_MAX + 6'd1,
			6'd3, 6'd30, 6'd31, RADIX_RESET, 6'($urandom_range(0, 63)),
			6'($urandom_range(0, 63))};

		sb              = new();
		cycle_count     = 0;
		calm            = 1'b0;
		hold_req        = 1'b0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		req.valid       = 1'b0;
		req.numerator   = '0;
		req.denominator = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed cases run at the reset base
		foreach (dir_num[i])
			send_fraction(dir_num[i], dir_den[i]);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			set_radix(phase_radix[ph]);
			if (ph == NUM_PHASES - 1)
				calm = 1'b1;
			// receiver stops while beats keep coming so the input backs up
			if (ph == 1)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 4 && i == PHASE_ITEMS / 2)
					drain();
				make_fraction(phase_radix[ph], num, den);
				send_fraction(num, den);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("finite_radix_fraction_test test passed");
		else
			$display("finite_radix_fraction_test test failed");
		$finish;
	end

endmodule
